/* design/tbb_pkg.sv */
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and codes of the bounding-box trimmer
// Payload structs of the pixel and box channels, pixel format codes and
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package tbb_pkg;

    // One transfer on the pixel channel.
    typedef struct packed {
        logic [31:0] pixel_a;
        logic [31:0] pixel_b;
    } pixel_t;

    // One transfer on the box channel.
    typedef struct packed {
        logic        not_empty;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
    } box_t;

    typedef enum logic [1:0] {
        FMT_RGBA    = 2'd0,
        FMT_GRAY    = 2'd1,
        FMT_INDEXED = 2'd2,
        FMT_BITMAP  = 2'd3
    } pixel_format_t;

    // Register indexes; register i sits at byte address 4*i.
    typedef enum logic [2:0] {
        REG_PIXEL_FORMAT   = 3'd0,
        REG_COMPARE_SOURCE = 3'd1,
        REG_REF_PIXEL      = 3'd2,
        REG_WINDOW_X       = 3'd3,
        REG_WINDOW_Y       = 3'd4,
        REG_WINDOW_W       = 3'd5,
        REG_WINDOW_H       = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_index_t;

    localparam int unsigned PADDR_BITS = 5;

endpackage : tbb_pkg

`default_nettype wire

/* design/trim_bounding_box.sv */
// ----------------------------------------------------------------------------
// trim_bounding_box: streaming bounding-box trimmer
// Finds the smallest rectangle of differing pixels in a raster-order window
// and reports it after the window's last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one pixel transfer per clock cycle, in raster order over the
// window set by window_x, window_y, window_w and window_h, as long as the
// input register does not stall: each pixel sits in the input register while
// a single compare and the min/max update of the box run, and the window's box
// is loaded into the result register at the last pixel; box_valid rises once
// the pixel that closes the window leaves the input register. The input
// register only holds a pixel back (pixel_stall) when that pixel closes a
// window and the previous box is still stalled in the result register; all
// other pixels keep moving regardless of the box channel. A pixel differs when
// it does not equal the reference colour (RGBA and gray pixels whose alpha is
// zero on both sides count as equal) or, with compare_source set, when it does
// not equal the same-position pixel of the second image. A window size of
// zero counts as one. Window registers are used modulo 2^COORD_BITS and
// box_x/box_y wrap the same way. An empty window reports not_empty low with
// all box fields zero. The user must write configuration through the APB-style
// port only while no window is in flight; the block itself does not enforce it.
// pready is always high and reads return the stored value.

module trim_bounding_box
    import tbb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready,

    // Pixel channel
    input  wire logic                  pixel_valid,
    output      logic                  pixel_stall,
    input  wire pixel_t                pixel,

    // Box channel
    output      logic                  box_valid,
    input  wire logic                  box_stall,
    output      box_t                  box
);

    localparam int unsigned C = COORD_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pixel_format_t pixel_format_reg;
    logic          compare_source_reg;
    logic [31:0]   ref_pixel_reg;
    logic [15:0]   window_x_reg;
    logic [15:0]   window_y_reg;
    logic [15:0]   window_w_reg;
    logic [15:0]   window_h_reg;

    reg_index_t    reg_index;
    logic          cfg_write;

    assign reg_index = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg   <= FMT_RGBA;
            compare_source_reg <= 1'b0;
            ref_pixel_reg      <= '0;
            window_x_reg       <= '0;
            window_y_reg       <= '0;
            window_w_reg       <= 16'd1;
            window_h_reg       <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_PIXEL_FORMAT:   pixel_format_reg   <= pixel_format_t'(pwdata[1:0]);
                REG_COMPARE_SOURCE: compare_source_reg <= pwdata[0];
                REG_REF_PIXEL:      ref_pixel_reg      <= pwdata;
                REG_WINDOW_X:       window_x_reg       <= pwdata[15:0];
                REG_WINDOW_Y:       window_y_reg       <= pwdata[15:0];
                REG_WINDOW_W:       window_w_reg       <= pwdata[15:0];
                REG_WINDOW_H:       window_h_reg       <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PIXEL_FORMAT:   prdata = 32'(pixel_format_reg);
            REG_COMPARE_SOURCE: prdata = 32'(compare_source_reg);
            REG_REF_PIXEL:      prdata = ref_pixel_reg;
            REG_WINDOW_X:       prdata = 32'(window_x_reg);
            REG_WINDOW_Y:       prdata = 32'(window_y_reg);
            REG_WINDOW_W:       prdata = 32'(window_w_reg);
            REG_WINDOW_H:       prdata = 32'(window_h_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    pixel_t s1_pixel_reg;
    logic   advance;        // the held pixel is consumed this cycle
    logic   pixel_take;

    assign pixel_stall = s1_valid_reg && !advance;
    assign pixel_take  = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            s1_pixel_reg <= pixel;
        end
    end

    // ------------------------------------------------------------------
    // Compare
    // ------------------------------------------------------------------
    logic differs;
    logic alpha_clear;

    always_comb
    begin
        case (pixel_format_reg)
            FMT_RGBA: alpha_clear = (s1_pixel_reg.pixel_a[31:24] == 8'd0)
                                    && (ref_pixel_reg[31:24] == 8'd0);
            FMT_GRAY: alpha_clear = (s1_pixel_reg.pixel_a[15:8] == 8'd0)
                                    && (ref_pixel_reg[15:8] == 8'd0);
            default:  alpha_clear = 1'b0;
        endcase

        if (compare_source_reg)
        begin
            differs = (s1_pixel_reg.pixel_a != s1_pixel_reg.pixel_b);
        end
        else
        begin
            differs = !alpha_clear && (s1_pixel_reg.pixel_a != ref_pixel_reg);
        end
    end

    // ------------------------------------------------------------------
    // Window position and box tracking
    // ------------------------------------------------------------------
    logic [C-1:0] col_count_reg, col_count_next;
    logic [C-1:0] row_count_reg, row_count_next;
    logic [C-1:0] min_col_reg, min_col_next;
    logic [C-1:0] max_col_reg, max_col_next;
    logic [C-1:0] min_row_reg, min_row_next;
    logic [C-1:0] max_row_reg, max_row_next;
    logic         found_reg, found_next;

    logic [C-1:0] wlim, hlim;
    logic         col_last, row_last, window_end;

    // A zero size counts as one.
    assign wlim = (window_w_reg[C-1:0] == '0) ? C'(1) : window_w_reg[C-1:0];
    assign hlim = (window_h_reg[C-1:0] == '0) ? C'(1) : window_h_reg[C-1:0];

    // At or beyond the last column/row ends it, so a mid-window change cannot hang.
    assign col_last   = (col_count_reg >= wlim - C'(1));
    assign row_last   = (row_count_reg >= hlim - C'(1));
    assign window_end = col_last && row_last;

    // The closing pixel waits only if the result register cannot take its box.
    assign advance = s1_valid_reg && (!window_end || !box_valid || !box_stall);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        max_row_next   = max_row_reg;
        found_next     = found_reg;

        if (advance)
        begin
            if (differs)
            begin
                if (!found_reg)
                begin
                    min_col_next = col_count_reg;
                    max_col_next = col_count_reg;
                    min_row_next = row_count_reg;
                    max_row_next = row_count_reg;
                    found_next   = 1'b1;
                end
                else
                begin
                    if (col_count_reg < min_col_reg) min_col_next = col_count_reg;
                    if (col_count_reg > max_col_reg) max_col_next = col_count_reg;
                    if (row_count_reg < min_row_reg) min_row_next = row_count_reg;
                    if (row_count_reg > max_row_reg) max_row_next = row_count_reg;
                end
            end

            if (!col_last)
            begin
                col_count_next = col_count_reg + C'(1);
            end
            else if (!row_last)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + C'(1);
            end
            else
            begin
                // Window done: start the next one from a clean slate.
                col_count_next = '0;
                row_count_next = '0;
                min_col_next   = '0;
                max_col_next   = '0;
                min_row_next   = '0;
                max_row_next   = '0;
                found_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            min_col_reg   <= '0;
            max_col_reg   <= '0;
            min_row_reg   <= '0;
            max_row_reg   <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            found_reg     <= found_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    // The box is formed from the state as it stands after the closing pixel
    // has been folded in, i.e. the values the update logic would keep.
    logic [C-1:0] fin_min_col, fin_max_col, fin_min_row, fin_max_row;
    logic [C-1:0] fin_x, fin_y, fin_w, fin_h;
    logic         fin_found;
    box_t         box_reg, box_next;
    logic         box_valid_reg, box_valid_next;
    logic         box_load;

    assign box_load = advance && window_end;

    always_comb
    begin
        fin_found   = found_reg;
        fin_min_col = min_col_reg;
        fin_max_col = max_col_reg;
        fin_min_row = min_row_reg;
        fin_max_row = max_row_reg;
        if (differs)
        begin
            if (!found_reg)
            begin
                fin_found   = 1'b1;
                fin_min_col = col_count_reg;
                fin_max_col = col_count_reg;
                fin_min_row = row_count_reg;
                fin_max_row = row_count_reg;
            end
            else
            begin
                if (col_count_reg < min_col_reg) fin_min_col = col_count_reg;
                if (col_count_reg > max_col_reg) fin_max_col = col_count_reg;
                if (row_count_reg < min_row_reg) fin_min_row = row_count_reg;
                if (row_count_reg > max_row_reg) fin_max_row = row_count_reg;
            end
        end

        // Corner sums and sizes wrap at the coordinate width.
        fin_x = window_x_reg[C-1:0] + fin_min_col;
        fin_y = window_y_reg[C-1:0] + fin_min_row;
        fin_w = fin_max_col - fin_min_col + C'(1);
        fin_h = fin_max_row - fin_min_row + C'(1);

        box_next = '0;
        if (fin_found)
        begin
            box_next.not_empty = 1'b1;
            box_next.box_x = 16'(fin_x);
            box_next.box_y = 16'(fin_y);
            box_next.box_w = 16'(fin_w);
            box_next.box_h = 16'(fin_h);
        end

        if (box_load)
        begin
            box_valid_next = 1'b1;
        end
        else if (!box_stall)
        begin
            box_valid_next = 1'b0;
        end
        else
        begin
            box_valid_next = box_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
        end
        else
        begin
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            box_reg <= box_next;
        end
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new box only appears after a held pixel closed a window.
    a_box_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(box_valid) |-> $past(s1_valid_reg))
        else $error("box appeared without a pixel closing the window");

    // Loading a box leaves the tracking state cleared for the next window.
    a_clear_after_box: assert property (@(posedge clk) disable iff (!rst_n)
        box_load |=> (col_count_reg == '0 && row_count_reg == '0 && !found_reg))
        else $error("window state not cleared after a box");

    // An empty window reports a zero-sized box.
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && !box.not_empty) |-> (box.box_w == 16'd0 && box.box_h == 16'd0
                                           && box.box_x == 16'd0 && box.box_y == 16'd0))
        else $error("empty box has nonzero fields");

    // Pixels are held back only while a closing pixel waits on a stalled box.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && window_end && box_valid && box_stall))
        else $error("pixel channel stalled without cause");

endmodule : trim_bounding_box

`default_nettype wire
